// ===== rtl/core/gls_pkg.sv =====
// ----------------------------------------------------------------------------
// gls_pkg: shared types and constants of the grip-limited speed governor
// Register indexes, field widths, the queue entry between front and back,
// the configuration bundle and the back-end sequencer states.
// ----------------------------------------------------------------------------
package gls_pkg;

  localparam int CurvW   = 20;
  localparam int SpeedW  = 16;
  localparam int CapW    = 15;
  localparam int MarginW = 17;
  localparam int GainW   = 16;
  localparam int StepW   = 17;
  localparam int GripW   = 16;
  localparam int DownW   = 20;
  localparam int PedalW  = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 20;

  // Division grip_accel * 2^28 / denom, one quotient bit per cycle.
  localparam int GripShift = 28;
  localparam int DivW      = GripW + GripShift;   // 44
  localparam int RootW     = DivW / 2;            // 22
  localparam int SremW     = RootW + 1;           // 23
  localparam int CntW      = 6;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;

  localparam logic [PedalW-1:0] PedalFull = PedalW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOP_SPEED_CAP   = 3'd0,
    REG_SAFETY_MARGIN   = 3'd1,
    REG_SPEED_GAIN      = 3'd2,
    REG_MAX_PEDAL_STEP  = 3'd3,
    REG_GRIP_ACCEL      = 3'd4,
    REG_DOWNFORCE_COEFF = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CapW-1:0]    top_speed_cap;
    logic [MarginW-1:0] safety_margin;
    logic [GainW-1:0]   speed_gain;
    logic [StepW-1:0]   max_pedal_step;
    logic [GripW-1:0]   grip_accel;
    logic [DownW-1:0]   downforce_coeff;
  } cfg_t;

  // Classified tick: use_cap set means the target is the cruise cap.
  typedef struct packed {
    logic              use_cap;
    logic [CurvW-1:0]  denom;
    logic [SpeedW-1:0] speed;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_SCALE,
    ST_TARGET,
    ST_ERR,
    ST_MULT,
    ST_LIMIT
  } back_state_t;

endpackage

// ===== rtl/core/grip_limited_speed_governor.sv =====
// ----------------------------------------------------------------------------
// grip_limited_speed_governor: grip-limited target speed and pedal control
// One result per control tick: throttle, brake and target speed.
// ----------------------------------------------------------------------------
// Push a tick (tightest curvature ahead, current speed) while full is low; pop
// one result per tick while empty is low. A tick whose curvature is zero, or
// whose curvature does not exceed the downforce coefficient, takes the cruise
// cap as target and goes from intake straight to target, error, gain multiply
// and the pedal limit. Any other tick runs intake, the restoring divider
// (grip_accel * 2^28 / denom, one quotient bit per cycle), the digit-by-digit
// square root, margin scale, target, error, gain multiply and the pedal limit.
// A two-entry queue holds ticks behind the back end. The
// result register lets the back end start the next tick while a result waits;
// that tick holds at the pedal limit step until the waiting beat is popped.
// Configuration registers are read live by both sides; write them only while
// the block is idle. Unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module grip_limited_speed_governor (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_write,
  input  logic [gls_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gls_pkg::CfgDatW-1:0]  cfg_data,
  // tick input
  input  logic                         push,
  output logic                         full,
  input  logic [gls_pkg::CurvW-1:0]    curvature_ahead,
  input  logic [gls_pkg::SpeedW-1:0]   speed,
  // results
  output logic                         empty,
  input  logic                         pop,
  output logic [gls_pkg::PedalW-1:0]   throttle,
  output logic [gls_pkg::PedalW-1:0]   brake,
  output logic [gls_pkg::CapW-1:0]     target_speed
);
  import gls_pkg::*;

  cfg_t   cfg;
  entry_t q_wr_data;
  entry_t q_rd_data;
  logic   q_wr;
  logic   q_rd;
  logic   q_full;
  logic   q_empty;
  logic   out_valid;

  // Register file: mask each write to its register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_speed_cap   <= CapW'(15360);
      cfg.safety_margin   <= MarginW'(52429);
      cfg.speed_gain      <= GainW'(13107);
      cfg.max_pedal_step  <= StepW'(66);
      cfg.grip_accel      <= GripW'(2511);
      cfg.downforce_coeff <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOP_SPEED_CAP:   cfg.top_speed_cap   <= cfg_data[CapW-1:0];
        REG_SAFETY_MARGIN:   cfg.safety_margin   <= cfg_data[MarginW-1:0];
        REG_SPEED_GAIN:      cfg.speed_gain      <= cfg_data[GainW-1:0];
        REG_MAX_PEDAL_STEP:  cfg.max_pedal_step  <= cfg_data[StepW-1:0];
        REG_GRIP_ACCEL:      cfg.grip_accel      <= cfg_data[GripW-1:0];
        REG_DOWNFORCE_COEFF: cfg.downforce_coeff <= cfg_data[DownW-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Front: accept and classify each beat.
  gls_front u_front (
    .push            (push),
    .curvature_ahead (curvature_ahead),
    .speed           (speed),
    .downforce_coeff (cfg.downforce_coeff),
    .q_full          (q_full),
    .full            (full),
    .q_wr            (q_wr),
    .q_data          (q_wr_data)
  );

  // Hold classified ticks until the back end is free.
  gls_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  // Back: iterate divide and root, then advance through the pedal law.
  gls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_rd         (q_rd),
    .pop          (pop && out_valid),
    .out_valid    (out_valid),
    .out_throttle (throttle),
    .out_brake    (brake),
    .out_target   (target_speed)
  );

  assign empty = !out_valid;

endmodule

// ===== rtl/core/gls_queue.sv =====
// ----------------------------------------------------------------------------
// gls_queue: short FIFO of classified ticks
// Decouples the accepting front from the iterating back end.
// ----------------------------------------------------------------------------
module gls_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  gls_pkg::entry_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output gls_pkg::entry_t rd_data,
  output logic           q_empty
);
  import gls_pkg::*;

  entry_t             mem [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QPtrW:0]     count;

  assign q_full  = (count == (QPtrW+1)'(QueueDepth));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !q_full) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en && !q_empty) rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr_en && !q_full, rd_en && !q_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/gls_front.sv =====
// ----------------------------------------------------------------------------
// gls_front: tick intake and classification
// Forms denom = curvature - downforce and flags ticks that take the cap.
// ----------------------------------------------------------------------------
module gls_front (
  input  logic                        push,
  input  logic [gls_pkg::CurvW-1:0]   curvature_ahead,
  input  logic [gls_pkg::SpeedW-1:0]  speed,
  input  logic [gls_pkg::DownW-1:0]   downforce_coeff,
  input  logic                        q_full,
  output logic                        full,
  output logic                        q_wr,
  output gls_pkg::entry_t             q_data
);
  import gls_pkg::*;

  logic [CurvW:0] diff;

  assign diff = {1'b0, curvature_ahead} - {1'b0, downforce_coeff};

  always_comb begin
    q_data.speed   = speed;
    q_data.denom   = diff[CurvW-1:0];
    // straight road, or downforce at least matching the curvature
    q_data.use_cap = (curvature_ahead == '0) || diff[CurvW] || (diff == '0);
  end

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule

// ===== rtl/core/gls_back.sv =====
// ----------------------------------------------------------------------------
// gls_back: target speed and pedal sequencer
// Serial divide, serial square root, margin scale (cap ticks skip all three), then the pedal law.
// ----------------------------------------------------------------------------
module gls_back (
  input  logic                        clk,
  input  logic                        rst,
  input  gls_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  gls_pkg::entry_t             q_data,
  output logic                        q_rd,
  input  logic                        pop,
  output logic                        out_valid,
  output logic [gls_pkg::PedalW-1:0]  out_throttle,
  output logic [gls_pkg::PedalW-1:0]  out_brake,
  output logic [gls_pkg::CapW-1:0]    out_target
);
  import gls_pkg::*;

  back_state_t state, state_next;

  logic [CntW-1:0]    cnt;
  logic [SpeedW-1:0]  speed_r;
  logic [CurvW-1:0]   denom_r;
  logic               use_cap_r;
  logic [DivW-1:0]    q;
  logic [CurvW-1:0]   rem;
  logic [SremW-1:0]   srem;
  logic [RootW-1:0]   root;
  logic [CapW+7:0]    scaled;
  logic [CapW-1:0]    target;
  logic               err_pos;
  logic               err_neg;
  logic [15:0]        mag;
  logic [31:0]        pprod;
  logic [PedalW-1:0]  last_throttle;

  logic               take;
  logic               out_free;
  logic               load_out;
  logic               div_last;
  logic               root_last;

  logic [CurvW:0]     rem_sh;
  logic               div_ge;
  logic [CurvW:0]     rem_sub;
  logic [SremW+1:0]   srem_sh;
  logic [SremW+1:0]   trial;
  logic               root_ge;
  logic [SremW+1:0]   srem_sub;
  logic [MarginW+RootW-1:0] mprod;
  logic [17:0]        err;
  logic [17:0]        err_abs;
  logic [23:0]        ped_raw;
  logic [PedalW-1:0]  ped;
  logic [PedalW-1:0]  raw_thr;
  logic [PedalW-1:0]  brk;
  logic signed [18:0] lo;
  logic signed [18:0] hi;
  logic signed [18:0] thr;

  assign out_free  = !out_valid || pop;
  assign div_last  = (cnt == CntW'(DivW - 1));
  assign root_last = (cnt == CntW'(RootW - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (!q_empty) state_next = q_data.use_cap ? ST_TARGET : ST_DIV;
      ST_DIV:    if (div_last) state_next = ST_ROOT;
      ST_ROOT:   if (root_last) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_TARGET;
      ST_TARGET: state_next = ST_ERR;
      ST_ERR:    state_next = ST_MULT;
      ST_MULT:   state_next = ST_LIMIT;
      ST_LIMIT:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take     = (state == ST_IDLE) && !q_empty;
    load_out = (state == ST_LIMIT) && out_free;
    q_rd     = take;
  end

  // datapath combinational terms
  always_comb begin
    rem_sh   = {rem, q[DivW-1]};
    rem_sub  = rem_sh - {1'b0, denom_r};
    div_ge   = (rem_sh >= {1'b0, denom_r});

    srem_sh  = {srem, q[DivW-1:DivW-2]};
    trial    = {1'b0, root, 2'b01};
    root_ge  = (srem_sh >= trial);
    srem_sub = srem_sh - trial;

    mprod    = cfg.safety_margin * root;

    err      = {3'b000, target} - {{2{speed_r[SpeedW-1]}}, speed_r};
    err_abs  = err[17] ? (18'd0 - err) : err;

    ped_raw  = pprod[31:8];
    ped      = (ped_raw > 24'(PedalFull)) ? PedalFull : ped_raw[PedalW-1:0];
    raw_thr  = err_pos ? ped : '0;
    brk      = err_neg ? ped : '0;

    lo       = $signed({2'b00, last_throttle}) - $signed({2'b00, cfg.max_pedal_step});
    hi       = $signed({2'b00, last_throttle}) + $signed({2'b00, cfg.max_pedal_step});
    thr      = $signed({2'b00, raw_thr});
    if (thr < lo) thr = lo;
    if (thr > hi) thr = hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
      last_throttle <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_DIV && div_last) || (state == ST_ROOT && root_last) || take) begin
        cnt <= '0;
      end else if (state == ST_DIV || state == ST_ROOT) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) begin
        out_valid     <= 1'b1;
        last_throttle <= thr[PedalW-1:0];
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          speed_r   <= q_data.speed;
          denom_r   <= q_data.denom;
          use_cap_r <= q_data.use_cap;
          q         <= {cfg.grip_accel, GripShift'(0)};
          rem       <= '0;
          srem      <= '0;
          root      <= '0;
        end
      end
      ST_DIV: begin
        rem <= div_ge ? rem_sub[CurvW-1:0] : rem_sh[CurvW-1:0];
        q   <= {q[DivW-2:0], div_ge};
      end
      ST_ROOT: begin
        srem <= root_ge ? srem_sub[SremW-1:0] : srem_sh[SremW-1:0];
        root <= {root[RootW-2:0], root_ge};
        q    <= {q[DivW-3:0], 2'b00};
      end
      ST_SCALE: begin
        scaled <= mprod[MarginW+RootW-1:16];
      end
      ST_TARGET: begin
        if (use_cap_r || (scaled >= (CapW+8)'(cfg.top_speed_cap))) begin
          target <= cfg.top_speed_cap;
        end else begin
          target <= scaled[CapW-1:0];
        end
      end
      ST_ERR: begin
        err_pos <= !err[17] && (err != '0);
        err_neg <= err[17];
        mag     <= err_abs[15:0];
      end
      ST_MULT: begin
        pprod <= mag * cfg.speed_gain;
      end
      ST_LIMIT: begin
        if (out_free) begin
          out_throttle <= thr[PedalW-1:0];
          out_brake    <= brk;
          out_target   <= target;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for the grip-limited speed governor
// Pushes control ticks through the input queue while the result side pops at
// its own random pace. A behavioral copy of the governor predicts throttle,
// brake and target speed for each accepted tick. Every popped beat is
// compared field by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module tb;
  import gls_pkg::*;

  // Index values outside the register map; writes to them must not land.
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  // Settle long enough for a full-length tick to clear the back end.
  localparam int IdleSettle = 90;
  // Bounds a run of roughly 1650 ticks at the slowest legal pace.
  localparam int CycleLimit = 1_000_000;
  localparam int RandomPhases = 16;
  localparam int TicksPerPhase = 100;

  typedef struct {
    logic [PedalW-1:0] throttle;
    logic [PedalW-1:0] brake;
    logic [CapW-1:0]   target_speed;
  } command_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDatW-1:0]  cfg_data;
  logic                push;
  logic                full;
  logic [CurvW-1:0]    curvature_ahead;
  logic [SpeedW-1:0]   speed;
  logic                empty;
  logic                pop;
  logic [PedalW-1:0]   throttle;
  logic [PedalW-1:0]   brake;
  logic [CapW-1:0]     target_speed;

  // Shadow of the register file and of the throttle carried between ticks.
  cfg_t                shadow_cfg;
  logic [PedalW-1:0]   held_throttle;

  // Predicted pedal commands, oldest first.
  command_t            predicted_commands[$];

  int                  error_count;
  int                  cycle_count;
  int                  push_quiet;
  int                  pop_quiet;

  grip_limited_speed_governor dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .curvature_ahead (curvature_ahead),
    .speed           (speed),
    .empty           (empty),
    .pop             (pop),
    .throttle        (throttle),
    .brake           (brake),
    .target_speed    (target_speed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Grip-limited target: cap on straights or when downforce wins, otherwise
  // margin * sqrt(grip * 2^28 / (curvature - downforce)), bounded by the cap.
  function automatic logic [CapW-1:0] grip_target(logic [CurvW-1:0] curv);
    longint     denom;
    logic [63:0] quot;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] scaled;
    denom = longint'(curv) - longint'(shadow_cfg.downforce_coeff);
    if (curv == '0 || denom <= 0) return shadow_cfg.top_speed_cap;
    quot = 64'(shadow_cfg.grip_accel);
    quot = (quot << GripShift) / denom;
    // Build the floor square root bit by bit from the top.
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= quot) root = trial;
    end
    scaled = (root * shadow_cfg.safety_margin) >> 16;
    if (scaled < shadow_cfg.top_speed_cap) return scaled[CapW-1:0];
    return shadow_cfg.top_speed_cap;
  endfunction

  // One control tick: target, proportional pedal, throttle slew against the
  // previous tick. Advances the held throttle.
  function automatic command_t govern_tick(logic [CurvW-1:0] curv,
                                           logic [SpeedW-1:0] spd);
    command_t res;
    longint   err;
    longint   mag;
    longint   pedal;
    longint   thr;
    longint   lo_lim;
    longint   hi_lim;
    res.target_speed = grip_target(curv);
    err = longint'(res.target_speed) - longint'($signed(spd));
    mag = (err < 0) ? -err : err;
    pedal = (mag * longint'(shadow_cfg.speed_gain)) >> 8;
    if (pedal > longint'(PedalFull)) pedal = longint'(PedalFull);
    res.brake = (err < 0) ? pedal[PedalW-1:0] : '0;
    thr = (err > 0) ? pedal : 0;
    lo_lim = longint'(held_throttle) - longint'(shadow_cfg.max_pedal_step);
    hi_lim = longint'(held_throttle) + longint'(shadow_cfg.max_pedal_step);
    if (thr < lo_lim) thr = lo_lim;
    if (thr > hi_lim) thr = hi_lim;
    held_throttle = thr[PedalW-1:0];
    res.throttle = held_throttle;
    return res;
  endfunction

  // Per-beat wait drawn at random, with occasional runs of back-to-back beats.
  function automatic int draw_gap(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one tick after a random gap; predict it at the accepting edge.
  // Push stays high on return so the next tick can follow with no gap.
  task automatic send_tick(input logic [CurvW-1:0] curv, input logic [SpeedW-1:0] spd);
    int gap;
    gap = draw_gap(push_quiet);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    curvature_ahead <= curv;
    speed           <= spd;
    do @(posedge clk); while (full);
    predicted_commands.push_back(govern_tick(curv, spd));
  endtask

  // Hold the write strobe high; the caller drops it with end_writes.
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_TOP_SPEED_CAP:   shadow_cfg.top_speed_cap   = value[CapW-1:0];
      REG_SAFETY_MARGIN:   shadow_cfg.safety_margin   = value[MarginW-1:0];
      REG_SPEED_GAIN:      shadow_cfg.speed_gain      = value[GainW-1:0];
      REG_MAX_PEDAL_STEP:  shadow_cfg.max_pedal_step  = value[StepW-1:0];
      REG_GRIP_ACCEL:      shadow_cfg.grip_accel      = value[GripW-1:0];
      REG_DOWNFORCE_COEFF: shadow_cfg.downforce_coeff = value[DownW-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
  endtask

  // Drop push, drain every predicted beat, then let the back end settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (predicted_commands.size() != 0) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: pop at a random pace and check each beat
  // --------------------------------------------------------------------------

  initial begin : result_drain
    int stall;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(pop_quiet);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin : result_check
    command_t want;
    if (!rst && pop && !empty) begin
      if (predicted_commands.size() == 0) begin
        $error("unexpected result beat: throttle %0d brake %0d target_speed %0d",
               throttle, brake, target_speed);
        error_count++;
      end else begin
        want = predicted_commands.pop_front();
        if (throttle !== want.throttle) begin
          $error("throttle: expected %0d, actual %0d", want.throttle, throttle);
          error_count++;
        end
        if (brake !== want.brake) begin
          $error("brake: expected %0d, actual %0d", want.brake, brake);
          error_count++;
        end
        if (target_speed !== want.target_speed) begin
          $error("target_speed: expected %0d, actual %0d", want.target_speed, target_speed);
          error_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("grip_limited_speed_governor regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: straight road, speed extremes, tightest and mildest bends.
  task automatic test_cruise_defaults();
    send_tick(20'd0, 16'h0000);
    send_tick(20'd0, 16'h8000);
    send_tick(20'd0, 16'h7FFF);
    send_tick(20'hFFFFF, 16'h0000);
    send_tick(20'd4096, 16'd15000);
    send_tick(20'd1, 16'h0000);
    wait_idle();
  endtask

  // Register extremes, masking of oversized writes and the corner cases.
  task automatic test_register_extremes();
    // Wide open: oversized writes mask to all ones, step above full scale.
    reg_write(REG_TOP_SPEED_CAP, 20'hFFFFF);
    reg_write(REG_SAFETY_MARGIN, 20'd65536);
    reg_write(REG_SPEED_GAIN, 20'hFFFFF);
    reg_write(REG_MAX_PEDAL_STEP, 20'hFFFFF);
    reg_write(REG_GRIP_ACCEL, 20'hFFFFF);
    reg_write(REG_DOWNFORCE_COEFF, 20'd0);
    end_writes();
    send_tick(20'd1, 16'h8000);
    send_tick(20'hFFFFF, 16'h7FFF);
    send_tick(20'd1, 16'h0000);
    wait_idle();

    // No grip drives the target to zero; margin above one stays bounded.
    reg_write(REG_GRIP_ACCEL, 20'd0);
    reg_write(REG_MAX_PEDAL_STEP, 20'd65536);
    reg_write(REG_SAFETY_MARGIN, 20'h1FFFF);
    end_writes();
    send_tick(20'd5000, 16'd100);
    send_tick(20'd5000, 16'hFF9C);
    send_tick(20'd0, 16'h7FFF);
    wait_idle();

    // Downforce dominates: zero and negative denominators, zero cap.
    reg_write(REG_GRIP_ACCEL, 20'd2511);
    reg_write(REG_DOWNFORCE_COEFF, 20'hFFFFF);
    reg_write(REG_TOP_SPEED_CAP, 20'd0);
    end_writes();
    send_tick(20'hFFFFF, 16'h0000);
    send_tick(20'd12345, 16'h8000);
    wait_idle();

    // Zero margin, zero gain, zero step: throttle frozen.
    reg_write(REG_DOWNFORCE_COEFF, 20'd0);
    reg_write(REG_TOP_SPEED_CAP, 20'd15360);
    reg_write(REG_SAFETY_MARGIN, 20'd0);
    reg_write(REG_SPEED_GAIN, 20'd0);
    reg_write(REG_MAX_PEDAL_STEP, 20'd0);
    end_writes();
    send_tick(20'd3000, 16'h0000);
    send_tick(20'd3000, 16'h8000);
    wait_idle();

    // Back to normal gains: throttle ramps by the step, brake does not.
    reg_write(REG_SAFETY_MARGIN, 20'd52429);
    reg_write(REG_SPEED_GAIN, 20'd13107);
    reg_write(REG_MAX_PEDAL_STEP, 20'd66);
    end_writes();
    send_tick(20'd3000, 16'h0000);
    send_tick(20'd3000, 16'h0000);
    send_tick(20'd0, 16'h7FFF);
    wait_idle();
  endtask

  // Writes to unmapped indexes must leave every register untouched.
  task automatic test_unknown_index();
    reg_write(RegUnusedLo, 20'hFFFFF);
    reg_write(RegUnusedHi, 20'h00000);
    end_writes();
    send_tick(20'd0, 16'h0000);
    send_tick(20'd4096, 16'd2000);
    wait_idle();
  endtask

  // Pick a register value: zero, range top, oversized, typical or random.
  function automatic logic [CfgDatW-1:0] pick_setting(int unsigned typical,
                                                      int unsigned top);
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return CfgDatW'(top);
      2:          return CfgDatW'($urandom());
      3, 4, 5, 6: return CfgDatW'(typical);
      default:    return CfgDatW'($urandom_range(top, 0));
    endcase
  endfunction

  // Random settings per phase; ticks are mostly bends ahead with speeds
  // close to the target so the slew limit stays in play.
  task automatic test_random_settings();
    logic [CurvW-1:0]  curv;
    logic [SpeedW-1:0] spd;
    longint            down;
    longint            pick;
    int                jitter;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      reg_write(REG_TOP_SPEED_CAP, pick_setting(15360, 32767));
      reg_write(REG_SAFETY_MARGIN, pick_setting(52429, 65536));
      reg_write(REG_SPEED_GAIN, pick_setting(13107, 65535));
      reg_write(REG_MAX_PEDAL_STEP, pick_setting($urandom_range(2000, 1), 65536));
      reg_write(REG_GRIP_ACCEL, pick_setting(2511, 65535));
      reg_write(REG_DOWNFORCE_COEFF, pick_setting($urandom_range(4000, 0), 1048575));
      if ($urandom_range(0, 3) == 0)
        reg_write($urandom_range(0, 1) ? RegUnusedLo : RegUnusedHi, CfgDatW'($urandom()));
      end_writes();

      for (int n = 0; n < TicksPerPhase; n++) begin
        down = shadow_cfg.downforce_coeff;
        case ($urandom_range(0, 9))
          0: curv = '0;
          1: curv = CurvW'($urandom_range(shadow_cfg.downforce_coeff, 0));
          2: curv = CurvW'($urandom());
          default: begin
            pick = down + $urandom_range(150000, 1);
            if (pick > 64'hFFFFF) pick = 64'hFFFFF;
            curv = pick[CurvW-1:0];
          end
        endcase
        case ($urandom_range(0, 9))
          0:       spd = SpeedW'($urandom());
          1:       spd = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          default: begin
            jitter = $urandom_range(2048, 0);
            pick = longint'(grip_target(curv)) + jitter - 1024;
            if (pick > 32767) pick = 32767;
            spd = pick[SpeedW-1:0];
          end
        endcase
        send_tick(curv, spd);
      end
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    push            <= 1'b0;
    curvature_ahead <= '0;
    speed           <= '0;
    error_count     = 0;
    cycle_count     = 0;
    push_quiet      = 0;
    pop_quiet       = 0;
    held_throttle   = '0;
    shadow_cfg.top_speed_cap   = CapW'(15360);
    shadow_cfg.safety_margin   = MarginW'(52429);
    shadow_cfg.speed_gain      = GainW'(13107);
    shadow_cfg.max_pedal_step  = StepW'(66);
    shadow_cfg.grip_accel      = GripW'(2511);
    shadow_cfg.downforce_coeff = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cruise_defaults();
    test_register_extremes();
    test_unknown_index();
    test_random_settings();

    // wait_idle has drained and settled; anything left over is a failure.
    if (error_count == 0 && predicted_commands.size() == 0) begin
      $display("grip_limited_speed_governor regression: pass");
    end else begin
      $display("grip_limited_speed_governor regression: fail");
    end
    $finish;
  end

endmodule
